// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the clss blocks
// all checks run on clk_i; CLSS_ASSERT checks are switched off while rst_ni is low, CLSS_ASSERT_ALWAYS ones are not
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with reset disable
`define CLSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked property that also holds during reset
`define CLSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/clss_pkg.sv =====
package clss_pkg;

  // sequencer states, codes as seen on machine_state
  typedef enum logic [2:0] {
    ST_WAIT  = 3'd0,
    ST_DRIVE = 3'd1,
    ST_PAUSE = 3'd2,
    ST_NEXT  = 3'd3,
    ST_EMERG = 3'd4
  } st_e;

  // pending request bit positions
  localparam int unsigned RQ_EMERG   = 0;
  localparam int unsigned RQ_START   = 1;
  localparam int unsigned RQ_FINISH  = 2;
  localparam int unsigned RQ_RESUME  = 3;
  localparam int unsigned RQ_RESTART = 4;
  localparam int unsigned RQ_W       = 5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd2;

  localparam int unsigned LINE_COUNT_W = 9;
  localparam int unsigned TIMER_W      = 16;
  localparam int unsigned ADDR_W       = 8;
  localparam int unsigned LINE_OUT_W   = 8;
  localparam int unsigned ADDR_SPAN    = 256;

  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd3;

  localparam int unsigned MAX_LINES_DEF    = 256;
  localparam int unsigned MAGNET_COUNT_DEF = 24;

  // control state kept in flops
  typedef struct packed {
    st_e               state;
    logic              paused;
    logic [RQ_W-1:0]   pend;
    logic [TIMER_W-1:0] elapsed;
  } ctl_t;

  // per-step request pulses and levels
  typedef struct packed {
    logic emergency;
    logic start;
    logic finish;
    logic pause;
    logic resume;
    logic restart;
    logic sensor;
    logic card;
    logic tick;
  } req_t;

endpackage

// ===== rtl/core/clss_ctrl.sv =====
module clss_ctrl
  import clss_pkg::*;
#(
  parameter int unsigned MaxLines = MAX_LINES_DEF
) (
  input  ctl_t                          ctl_i,
  input  logic [$clog2(MaxLines)-1:0]   ptr_i,
  input  logic [$clog2(MaxLines+1)-1:0] cnt_i,
  input  logic                          fwd_i,
  input  logic [TIMER_W-1:0]            limit_i,
  input  req_t                          req_i,
  output ctl_t                          ctl_o,
  output logic [$clog2(MaxLines)-1:0]   ptr_o,
  output logic                          load_o
);

  localparam int unsigned AW = $clog2(MaxLines);
  localparam int unsigned CW = $clog2(MaxLines + 1);

  typedef struct packed {
    logic [RQ_W-1:0] take;
    logic            clr_line;
    logic            step;
    logic            load;
    logic            set_pause;
    logic            clr_pause;
    logic            clr_elapsed;
  } act_t;

  logic [RQ_W-1:0]    pend_m;
  logic               paused_m;
  logic [TIMER_W-1:0] elapsed_m;
  logic               overrun;
  logic [AW-1:0]      ptr_step;
  st_e                state_d;
  act_t               act;

  // latch the pulses and run the tick timer before deciding
  always_comb begin
    pend_m              = ctl_i.pend;
    pend_m[RQ_EMERG]    = ctl_i.pend[RQ_EMERG] | req_i.emergency;
    pend_m[RQ_START]    = ctl_i.pend[RQ_START] | req_i.start;
    pend_m[RQ_FINISH]   = ctl_i.pend[RQ_FINISH] | req_i.finish;
    pend_m[RQ_RESUME]   = ctl_i.pend[RQ_RESUME] | req_i.resume;
    pend_m[RQ_RESTART]  = ctl_i.pend[RQ_RESTART] | req_i.restart;
  end

  assign paused_m  = ctl_i.paused | req_i.pause;
  assign elapsed_m = (req_i.tick && (ctl_i.elapsed != '1)) ?
                     ctl_i.elapsed + TIMER_W'(1) : ctl_i.elapsed;
  assign overrun   = elapsed_m > limit_i;

  // wrapping line step
  always_comb begin
    if (fwd_i) begin
      ptr_step = ((CW'(ptr_i) + CW'(1)) >= cnt_i) ? '0 : ptr_i + AW'(1);
    end else begin
      ptr_step = (ptr_i == '0) ? AW'(cnt_i - CW'(1)) : ptr_i - AW'(1);
    end
  end

  // next state and actions
  always_comb begin
    state_d = ctl_i.state;
    act     = '0;
    unique case (ctl_i.state)
      ST_DRIVE: begin
        if (pend_m[RQ_EMERG]) begin
          act.take[RQ_EMERG] = 1'b1;
          state_d            = ST_EMERG;
        end else if (pend_m[RQ_FINISH]) begin
          act.take[RQ_FINISH] = 1'b1;
          act.clr_line        = 1'b1;
          state_d             = ST_WAIT;
        end else if (paused_m || overrun) begin
          act.set_pause = 1'b1;
          state_d       = ST_PAUSE;
        end else if (req_i.sensor) begin
          state_d = ST_NEXT;
        end
      end
      ST_PAUSE: begin
        if (pend_m[RQ_EMERG]) begin
          act.take[RQ_EMERG] = 1'b1;
          act.clr_pause      = 1'b1;
          state_d            = ST_EMERG;
        end else if (pend_m[RQ_FINISH]) begin
          act.take[RQ_FINISH] = 1'b1;
          act.clr_pause       = 1'b1;
          act.clr_line        = 1'b1;
          state_d             = ST_WAIT;
        end else if (pend_m[RQ_RESUME]) begin
          act.take[RQ_RESUME] = 1'b1;
          act.clr_pause       = 1'b1;
          act.clr_elapsed     = 1'b1;
          state_d             = ST_DRIVE;
        end
      end
      ST_NEXT: begin
        if (pend_m[RQ_EMERG]) begin
          act.take[RQ_EMERG] = 1'b1;
          state_d            = ST_EMERG;
        end else if (pend_m[RQ_FINISH]) begin
          act.take[RQ_FINISH] = 1'b1;
          act.clr_line        = 1'b1;
          state_d             = ST_WAIT;
        end else if (paused_m) begin
          state_d = ST_PAUSE;
        end else if (!req_i.sensor) begin
          act.step = 1'b1;
          act.load = 1'b1;
          state_d  = ST_DRIVE;
        end
      end
      ST_EMERG: begin
        if (!req_i.card || pend_m[RQ_FINISH]) begin
          act.take[RQ_FINISH] = 1'b1;
          act.clr_line        = 1'b1;
          state_d             = ST_WAIT;
        end else if (pend_m[RQ_RESTART]) begin
          act.take[RQ_RESTART] = 1'b1;
          act.set_pause        = 1'b1;
          state_d              = ST_PAUSE;
        end
      end
      default: begin
        state_d = ST_WAIT;
        if (pend_m[RQ_EMERG]) begin
          act.take[RQ_EMERG] = 1'b1;
          state_d            = ST_EMERG;
        end else if (pend_m[RQ_START]) begin
          act.take[RQ_START] = 1'b1;
          act.load           = 1'b1;
          state_d            = ST_DRIVE;
        end
      end
    endcase
  end

  // apply actions
  always_comb begin
    ctl_o.state   = state_d;
    ctl_o.pend    = pend_m & ~act.take;
    ctl_o.paused  = act.set_pause ? 1'b1 : (act.clr_pause ? 1'b0 : paused_m);
    ctl_o.elapsed = (act.load || act.clr_elapsed) ? '0 : elapsed_m;
    if (act.clr_line) begin
      ptr_o = '0;
    end else if (act.step) begin
      ptr_o = ptr_step;
    end else begin
      ptr_o = ptr_i;
    end
    load_o = act.load;
  end

endmodule

// ===== rtl/core/card_line_solenoid_sequencer_unit.sv =====
// card line solenoid sequencer: steps through the lines of a punched card held in an
// on-chip line store and drives one line pattern at a time onto the magnets. an input
// transfer with cmd set writes one card line; with cmd clear it is one control step
// (request pulses, feed sensor, card present, timebase tick) and yields one result
// transfer with the magnet word, state, line pointer and pause flag after that step.
// a write transfer also yields one result, reporting the unchanged state. one input
// transfer is taken per clock unless the output stalls with stage 1 full; results pass
// stage 1 (beside the registered store read of a line fetch) and the result register.
// the user writes configuration via cfg_we_i/cfg_idx_i/cfg_wdata_i while no transfer is
// in flight; the block does not enforce it. card lines must be written before they are driven.
module card_line_solenoid_sequencer_unit
  import clss_pkg::*;
#(
  parameter int unsigned MaxLines    = MAX_LINES_DEF,
  parameter int unsigned MagnetCount = MAGNET_COUNT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration writes
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic [ADDR_W-1:0]       line_addr_i,
  input  logic [MagnetCount-1:0]  line_data_i,
  input  logic                    emergency_i,
  input  logic                    start_req_i,
  input  logic                    finish_i,
  input  logic                    pause_req_i,
  input  logic                    resume_i,
  input  logic                    restart_i,
  input  logic                    sensor_i,
  input  logic                    card_present_i,
  input  logic                    tick_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [MagnetCount-1:0]  solenoids_o,
  output logic [2:0]              machine_state_o,
  output logic [LINE_OUT_W-1:0]   current_line_o,
  output logic                    paused_o
);

  localparam int unsigned AW = $clog2(MaxLines);
  localparam int unsigned CW = $clog2(MaxLines + 1);
  localparam int unsigned CntReset = (MaxLines < 256) ? MaxLines : 256;

  // first pipeline stage, held beside the registered store read data
  typedef struct packed {
    logic                  load;
    st_e                   state;
    logic [LINE_OUT_W-1:0] line;
    logic                  paused;
  } s1_t;

  // configuration
  logic [CW-1:0]      cnt_q;
  logic [CW-1:0]      cnt_wr;
  logic               fwd_q;
  logic [TIMER_W-1:0] limit_q;
  logic [LINE_COUNT_W-1:0] lc_raw;

  // control state
  ctl_t          ctl_q, ctl_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          load;
  req_t          req;

  // line store
  logic [MagnetCount-1:0] store_mem [MaxLines];
  logic [MagnetCount-1:0] rd_q;
  logic [AW-1:0]          addr_map [ADDR_SPAN];
  logic                   wr_en;
  logic                   rd_en;

  // pipeline
  logic                   accept;
  logic                   step_en;
  logic                   s1_valid_q;
  s1_t                    s1_q;
  logic                   adv;
  logic [MagnetCount-1:0] pattern_q;
  logic [MagnetCount-1:0] pattern_d;

  // ---------------------------------------------------------------------------
  // configuration: the line count is clamped to 1..MaxLines when written
  // ---------------------------------------------------------------------------
  assign lc_raw = cfg_wdata_i[LINE_COUNT_W-1:0];

  always_comb begin
    if (lc_raw == '0) begin
      cnt_wr = CW'(1);
    end else if (int'(lc_raw) > int'(MaxLines)) begin
      cnt_wr = CW'(MaxLines);
    end else begin
      cnt_wr = CW'(lc_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= CW'(CntReset);
      fwd_q   <= 1'b1;
      limit_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LINE_COUNT: cnt_q   <= cnt_wr;
        CFG_FORWARD:    fwd_q   <= cfg_wdata_i[0];
        CFG_TIMEOUT:    limit_q <= cfg_wdata_i[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // control step, evaluated at the input transfer
  // ---------------------------------------------------------------------------
  assign req = '{
    emergency: emergency_i,
    start:     start_req_i,
    finish:    finish_i,
    pause:     pause_req_i,
    resume:    resume_i,
    restart:   restart_i,
    sensor:    sensor_i,
    card:      card_present_i,
    tick:      tick_i
  };

  clss_ctrl #(
    .MaxLines(MaxLines)
  ) u_ctrl (
    .ctl_i  (ctl_q),
    .ptr_i  (ptr_q),
    .cnt_i  (cnt_q),
    .fwd_i  (fwd_q),
    .limit_i(limit_q),
    .req_i  (req),
    .ctl_o  (ctl_d),
    .ptr_o  (ptr_d),
    .load_o (load)
  );

  assign accept  = in_valid_i & in_ready_o;
  assign step_en = accept & ~cmd_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{state: ST_WAIT, paused: 1'b0, pend: '0, elapsed: '0};
      ptr_q <= '0;
    end else if (step_en) begin
      ctl_q <= ctl_d;
      ptr_q <= ptr_d;
    end
  end

  // ---------------------------------------------------------------------------
  // line store: one write or one read per transfer, read data registered
  // ---------------------------------------------------------------------------
  // store address is the card line taken modulo the store depth
  for (genvar a = 0; a < ADDR_SPAN; a++) begin : g_addr_map
    assign addr_map[a] = AW'(a % MaxLines);
  end

  assign wr_en = accept & cmd_i;
  assign rd_en = step_en & load;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[addr_map[line_addr_i]] <= line_data_i;
    end
    if (rd_en) begin
      rd_q <= store_mem[ptr_d];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1 holds the transfer outcome beside the read data until the result register takes it
  // ---------------------------------------------------------------------------
  assign adv        = s1_valid_q & (~out_valid_o | out_ready_i);
  assign in_ready_o = ~s1_valid_q | ~out_valid_o | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (cmd_i) begin
        // a line write reports the state as it stands
        s1_q <= '{load: 1'b0, state: ctl_q.state,
                  line: LINE_OUT_W'(ptr_q), paused: ctl_q.paused};
      end else begin
        s1_q <= '{load: load, state: ctl_d.state,
                  line: LINE_OUT_W'(ptr_d), paused: ctl_d.paused};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register; the current pattern follows the results in order
  // ---------------------------------------------------------------------------
  assign pattern_d = s1_q.load ? rd_q : pattern_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q   <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (adv) begin
        pattern_q <= pattern_d;
      end
      if (adv) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // magnets only energised while driving
      solenoids_o     <= (s1_q.state == ST_DRIVE) ? pattern_d : '0;
      machine_state_o <= s1_q.state;
      current_line_o  <= s1_q.line;
      paused_o        <= s1_q.paused;
    end
  end

endmodule

// ===== rtl/core/clss_checker.sv =====
`include "assert_macros.svh"

module clss_checker
  import clss_pkg::*;
#(
  parameter int unsigned MagnetCount = MAGNET_COUNT_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [MagnetCount-1:0] solenoids_o,
  input logic [2:0]             machine_state_o,
  input logic [LINE_OUT_W-1:0]  current_line_o,
  input logic                   paused_o
);

  // a stalled result keeps its payload
  `CLSS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(solenoids_o) && $stable(machine_state_o) && $stable(current_line_o) && $stable(paused_o), "result changed while stalled")

  // magnets are dark outside the driving state
  `CLSS_ASSERT(a_sol_idle, out_valid_o && (machine_state_o != ST_DRIVE) |-> solenoids_o == '0, "magnets driven outside driving state")

  // paused state always carries the pause flag
  `CLSS_ASSERT(a_pause_flag, out_valid_o && (machine_state_o == ST_PAUSE) |-> paused_o, "paused state without pause flag")

  // waiting always sits at line zero
  `CLSS_ASSERT(a_wait_line, out_valid_o && (machine_state_o == ST_WAIT) |-> current_line_o == '0, "waiting with nonzero line")

endmodule

bind card_line_solenoid_sequencer_unit clss_checker #(
  .MagnetCount(MagnetCount)
) u_clss_checker (.*);

// ===== tb/card_line_solenoid_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps

module card_line_solenoid_sequencer_unit_tb;
  import clss_pkg::*;

  localparam int unsigned MAGNETS          = MAGNET_COUNT_DEF;
  localparam int unsigned STALL_LIMIT      = 2000;  // cycles with no transfer on either side
  localparam int unsigned SETTLE_CYCLES    = 6;     // slack after the last result
  localparam int unsigned LONG_HOLD_CYCLES = 150;   // one long output stall to back the block up
  localparam int unsigned RANDOM_PHASES    = 8;
  localparam int unsigned ITEMS_PER_PHASE  = 36;
  localparam int unsigned MAX_PRINTED      = 100;

  // control step flags, used to spell out the directed sequence
  localparam int unsigned F_EMERG   = 1 << 0;
  localparam int unsigned F_START   = 1 << 1;
  localparam int unsigned F_FINISH  = 1 << 2;
  localparam int unsigned F_PAUSE   = 1 << 3;
  localparam int unsigned F_RESUME  = 1 << 4;
  localparam int unsigned F_RESTART = 1 << 5;
  localparam int unsigned F_SENSOR  = 1 << 6;
  localparam int unsigned F_TICK    = 1 << 7;
  localparam int unsigned F_NO_CARD = 1 << 8;

  // one input transfer: a card line write or a control step
  typedef struct packed {
    logic               cmd;
    logic [ADDR_W-1:0]  line_addr;
    logic [MAGNETS-1:0] line_data;
    logic               emergency;
    logic               start_req;
    logic               finish;
    logic               pause_req;
    logic               resume;
    logic               restart;
    logic               sensor;
    logic               card_present;
    logic               tick;
  } line_item_t;

  // one result transfer
  typedef struct packed {
    logic [MAGNETS-1:0]    solenoids;
    logic [2:0]            machine_state;
    logic [LINE_OUT_W-1:0] current_line;
    logic                  paused;
  } step_result_t;

  // mirror of the sequencer plus the queue of results it still owes
  class sequencer_scoreboard;
    logic [LINE_COUNT_W-1:0] line_count    = 9'd256;
    logic                    forward       = 1'b1;
    logic [TIMER_W-1:0]      timeout_limit = TIMEOUT_RESET;

    st_e                     state      = ST_WAIT;
    logic [LINE_OUT_W-1:0]   line_ptr   = '0;
    logic                    pause_flag = 1'b0;
    logic [RQ_W-1:0]         pend       = '0;
    logic [TIMER_W-1:0]      elapsed    = '0;
    logic [MAGNETS-1:0]      pattern    = '0;
    logic [MAGNETS-1:0]      card_lines [ADDR_SPAN];

    step_result_t            expected_steps [$];
    int unsigned             mismatches = 0;
    int unsigned             checked    = 0;

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LINE_COUNT: line_count = data[LINE_COUNT_W-1:0];
        CFG_FORWARD:    forward = data[0];
        CFG_TIMEOUT:    timeout_limit = data;
        default: ;
      endcase
    endfunction

    function bit claim(int unsigned rq);
      if (pend[rq]) begin
        pend[rq] = 1'b0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void fetch_line();
      pattern = card_lines[line_ptr];
      elapsed = '0;
    endfunction

    function int unsigned waiting();
      return expected_steps.size();
    endfunction

    function void note_transfer(line_item_t it);
      step_result_t want;
      logic         overrun;
      int unsigned  span;
      if (it.cmd) begin
        card_lines[it.line_addr] = it.line_data;
      end else begin
        if (it.emergency) pend[RQ_EMERG] = 1'b1;
        if (it.start_req) pend[RQ_START] = 1'b1;
        if (it.finish) pend[RQ_FINISH] = 1'b1;
        if (it.pause_req) pause_flag = 1'b1;
        if (it.resume) pend[RQ_RESUME] = 1'b1;
        if (it.restart) pend[RQ_RESTART] = 1'b1;
        if (it.tick && elapsed != '1) elapsed = elapsed + 1'b1;
        overrun = (elapsed > timeout_limit);
        case (state)
          ST_DRIVE: begin
            if (claim(RQ_EMERG)) begin
              state = ST_EMERG;
            end else if (claim(RQ_FINISH)) begin
              line_ptr = '0;
              state = ST_WAIT;
            end else if (pause_flag || overrun) begin
              pause_flag = 1'b1;
              state = ST_PAUSE;
            end else if (it.sensor) begin
              state = ST_NEXT;
            end
          end
          ST_PAUSE: begin
            if (claim(RQ_EMERG)) begin
              pause_flag = 1'b0;
              state = ST_EMERG;
            end else if (claim(RQ_FINISH)) begin
              pause_flag = 1'b0;
              line_ptr = '0;
              state = ST_WAIT;
            end else if (claim(RQ_RESUME)) begin
              pause_flag = 1'b0;
              elapsed = '0;
              state = ST_DRIVE;
            end
          end
          ST_NEXT: begin
            if (claim(RQ_EMERG)) begin
              state = ST_EMERG;
            end else if (claim(RQ_FINISH)) begin
              line_ptr = '0;
              state = ST_WAIT;
            end else if (pause_flag) begin
              state = ST_PAUSE;
            end else if (!it.sensor) begin
              // 0 lines acts as 1, anything above the store size as the store size
              span = (line_count == 0) ? 1 :
                     (line_count > ADDR_SPAN) ? ADDR_SPAN : line_count;
              if (forward) begin
                line_ptr = (line_ptr + 32'd1 >= span) ? '0 : line_ptr + 1'b1;
              end else begin
                line_ptr = (line_ptr == 0) ? 8'(span - 1) : line_ptr - 1'b1;
              end
              fetch_line();
              state = ST_DRIVE;
            end
          end
          ST_EMERG: begin
            if (!it.card_present || pend[RQ_FINISH]) begin
              pend[RQ_FINISH] = 1'b0;
              line_ptr = '0;
              state = ST_WAIT;
            end else if (claim(RQ_RESTART)) begin
              pause_flag = 1'b1;
              state = ST_PAUSE;
            end
          end
          default: begin
            state = ST_WAIT;
            if (claim(RQ_EMERG)) begin
              state = ST_EMERG;
            end else if (claim(RQ_START)) begin
              fetch_line();
              state = ST_DRIVE;
            end
          end
        endcase
      end
      want.solenoids     = (state == ST_DRIVE) ? pattern : '0;
      want.machine_state = state;
      want.current_line  = line_ptr;
      want.paused        = pause_flag;
      expected_steps.push_back(want);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      // keep the log readable when the block is badly off
      if (mismatches <= MAX_PRINTED)
        $display("mismatch at result %0d: %s got 0x%0h, wanted 0x%0h", checked, what, got, want);
    endtask

    task check_result(step_result_t got);
      step_result_t want;
      if (expected_steps.size() == 0) begin
        report_mismatch("result with nothing outstanding", 32'(got.machine_state), 32'd0);
      end else begin
        want = expected_steps.pop_front();
        if (got.solenoids !== want.solenoids)
          report_mismatch("solenoids", 32'(got.solenoids), 32'(want.solenoids));
        if (got.machine_state !== want.machine_state)
          report_mismatch("machine_state", 32'(got.machine_state), 32'(want.machine_state));
        if (got.current_line !== want.current_line)
          report_mismatch("current_line", 32'(got.current_line), 32'(want.current_line));
        if (got.paused !== want.paused)
          report_mismatch("paused", 32'(got.paused), 32'(want.paused));
      end
      checked++;
    endtask
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    cmd_i;
  logic [ADDR_W-1:0]       line_addr_i;
  logic [MAGNETS-1:0]      line_data_i;
  logic                    emergency_i;
  logic                    start_req_i;
  logic                    finish_i;
  logic                    pause_req_i;
  logic                    resume_i;
  logic                    restart_i;
  logic                    sensor_i;
  logic                    card_present_i;
  logic                    tick_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [MAGNETS-1:0]      solenoids_o;
  logic [2:0]              machine_state_o;
  logic [LINE_OUT_W-1:0]   current_line_o;
  logic                    paused_o;

  sequencer_scoreboard sb;
  line_item_t          stimulus [$];
  bit                  send_idle;
  bit                  recv_idle;
  bit                  hold_requested;
  int unsigned         items_sent;
  int unsigned         line_writes;
  int unsigned         settings_used;

  card_line_solenoid_sequencer_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .line_addr_i    (line_addr_i),
    .line_data_i    (line_data_i),
    .emergency_i    (emergency_i),
    .start_req_i    (start_req_i),
    .finish_i       (finish_i),
    .pause_req_i    (pause_req_i),
    .resume_i       (resume_i),
    .restart_i      (restart_i),
    .sensor_i       (sensor_i),
    .card_present_i (card_present_i),
    .tick_i         (tick_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .solenoids_o    (solenoids_o),
    .machine_state_o(machine_state_o),
    .current_line_o (current_line_o),
    .paused_o       (paused_o)
  );

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic line_item_t control_step(int unsigned flags);
    line_item_t it;
    it = '0;
    it.emergency    = (flags & F_EMERG) != 0;
    it.start_req    = (flags & F_START) != 0;
    it.finish       = (flags & F_FINISH) != 0;
    it.pause_req    = (flags & F_PAUSE) != 0;
    it.resume       = (flags & F_RESUME) != 0;
    it.restart      = (flags & F_RESTART) != 0;
    it.sensor       = (flags & F_SENSOR) != 0;
    it.tick         = (flags & F_TICK) != 0;
    it.card_present = (flags & F_NO_CARD) == 0;
    return it;
  endfunction

  function automatic line_item_t write_item(logic [ADDR_W-1:0] addr, logic [MAGNETS-1:0] data);
    line_item_t it;
    it = '0;
    it.cmd       = 1'b1;
    it.line_addr = addr;
    it.line_data = data;
    return it;
  endfunction

  // mostly well-formed control traffic: requests are pulses (emergency, finish and
  // pause rare ones), the sensor toggles freely, so the machine walks drive, next
  // line and pause paths; a few items are plain noise and some rewrite card lines
  function automatic line_item_t random_item();
    line_item_t          it;
    int unsigned         roll;
    logic [MAGNETS-1:0]  data;
    roll = $urandom_range(0, 99);
    data = MAGNETS'($urandom);
    if (chance(12)) data = chance(50) ? '0 : '1;
    if (roll < 6) begin
      it = control_step($urandom_range(0, 511));
      it.cmd       = 1'($urandom_range(0, 1));
      it.line_addr = ADDR_W'($urandom);
      it.line_data = data;
    end else if (roll < 20) begin
      it = write_item(ADDR_W'($urandom), data);
    end else begin
      it = '0;
      it.emergency    = chance(4);
      it.start_req    = chance(25);
      it.finish       = chance(5);
      it.pause_req    = chance(8);
      it.resume       = chance(30);
      it.restart      = chance(30);
      it.sensor       = chance(50);
      it.card_present = chance(93);
      it.tick         = chance(40);
      // ignored fields of a control step carry garbage
      it.line_addr    = ADDR_W'($urandom);
      it.line_data    = data;
    end
    return it;
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.apply_register(idx, data);
  endtask

  task automatic apply_setting(logic [LINE_COUNT_W-1:0] count, logic fwd,
                               logic [TIMER_W-1:0] limit);
    write_register(CFG_LINE_COUNT, CFG_DATA_W'(count));
    write_register(CFG_FORWARD, CFG_DATA_W'(fwd));
    write_register(CFG_TIMEOUT, limit);
    settings_used++;
  endtask

  // sender: offers each queued item, valid held with a steady payload until the transfer
  task automatic drive_items();
    line_item_t  it;
    int unsigned gap;
    @(negedge clk_i);
    while (stimulus.size() != 0) begin
      it  = stimulus.pop_front();
      gap = send_idle ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      cmd_i          <= it.cmd;
      line_addr_i    <= it.line_addr;
      line_data_i    <= it.line_data;
      emergency_i    <= it.emergency;
      start_req_i    <= it.start_req;
      finish_i       <= it.finish;
      pause_req_i    <= it.pause_req;
      resume_i       <= it.resume;
      restart_i      <= it.restart;
      sensor_i       <= it.sensor;
      card_present_i <= it.card_present;
      tick_i         <= it.tick;
      in_valid_i     <= 1'b1;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      sb.note_transfer(it);
      items_sent++;
      if (it.cmd) line_writes++;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  // wait for every owed result, then SETTLE_CYCLES of slack before touching registers
  task automatic drain();
    while (sb.waiting() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // receiver: random back-pressure per result, and one long hold when asked
  initial begin
    step_result_t got;
    int unsigned  stall;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      stall = recv_idle ? $urandom_range(0, 9) : 0;
      if (hold_requested) begin
        stall = LONG_HOLD_CYCLES;
        hold_requested = 1'b0;
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got.solenoids     = solenoids_o;
      got.machine_state = machine_state_o;
      got.current_line  = current_line_o;
      got.paused        = paused_o;
      sb.check_result(got);
    end
  end

  // watchdog: ends the run once nothing has moved for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("no transfer for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [LINE_COUNT_W-1:0] counts [RANDOM_PHASES];
    logic                    fwds   [RANDOM_PHASES];
    logic [TIMER_W-1:0]      limits [RANDOM_PHASES];
    int unsigned             mode;

    // settings for the random phases: small cards both ways, count 0 and
    // counts past the store size, timeout 0 and the widest values
    counts = '{9'd3, 9'd1, 9'd0, 9'd256, 9'd511, 9'd300, 9'd2, 9'd4};
    fwds   = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    limits = '{16'd2, 16'd0, 16'd1, 16'hFFFF, 16'hFFFE, 16'd5, 16'd1, 16'd3};
    counts[RANDOM_PHASES-1] = LINE_COUNT_W'($urandom_range(1, 8));
    fwds[RANDOM_PHASES-1]   = 1'($urandom_range(0, 1));
    limits[RANDOM_PHASES-1] = TIMER_W'($urandom_range(0, 6));

    sb             = new;
    send_idle      = 1'b1;
    recv_idle      = 1'b1;
    hold_requested = 1'b0;
    items_sent     = 0;
    line_writes    = 0;
    settings_used  = 1;

    // every input known from time zero, with reset held low first
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_LINE_COUNT;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    cmd_i          = 1'b0;
    line_addr_i    = '0;
    line_data_i    = '0;
    emergency_i    = 1'b0;
    start_req_i    = 1'b0;
    finish_i       = 1'b0;
    pause_req_i    = 1'b0;
    resume_i       = 1'b0;
    restart_i      = 1'b0;
    sensor_i       = 1'b0;
    card_present_i = 1'b0;
    tick_i         = 1'b0;
    out_ready_i    = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // load the whole card first so no step ever fetches an unwritten line
    for (int unsigned a = 0; a < ADDR_SPAN; a++) begin
      case (a)
        0:       stimulus.push_back(write_item(ADDR_W'(a), '1));
        1:       stimulus.push_back(write_item(ADDR_W'(a), '0));
        2:       stimulus.push_back(write_item(ADDR_W'(a), 24'hAAAAAA));
        3:       stimulus.push_back(write_item(ADDR_W'(a), 24'h555555));
        default: stimulus.push_back(write_item(ADDR_W'(a), MAGNETS'($urandom)));
      endcase
    end
    drive_items();
    drain();

    // directed walk on a three line card with a short timeout
    apply_setting(9'd3, 1'b1, 16'd2);
    stimulus.push_back(control_step(0));                              // idle while waiting
    stimulus.push_back(write_item(8'hFF, 24'h800001));                // write with every flag set
    stimulus[$].emergency = 1'b1;
    stimulus[$].start_req = 1'b1;
    stimulus[$].finish    = 1'b1;
    stimulus[$].pause_req = 1'b1;
    stimulus[$].resume    = 1'b1;
    stimulus[$].restart   = 1'b1;
    stimulus[$].sensor    = 1'b1;
    stimulus[$].tick      = 1'b1;
    stimulus.push_back(control_step(F_START));                        // drive line 0
    stimulus.push_back(control_step(F_SENSOR));                       // sensor up, next line
    stimulus.push_back(control_step(F_PAUSE | F_SENSOR));             // pause from next line
    stimulus.push_back(control_step(F_RESUME));                       // back to driving
    stimulus.push_back(control_step(F_TICK));
    stimulus.push_back(control_step(F_TICK));
    stimulus.push_back(control_step(F_TICK));                         // timer overrun, forced pause
    stimulus.push_back(control_step(F_RESUME));
    for (int unsigned n = 0; n < 3; n++) begin                        // lines 1, 2, then wrap to 0
      stimulus.push_back(control_step(F_SENSOR));
      stimulus.push_back(control_step(0));
    end
    stimulus.push_back(control_step(F_EMERG | F_START));              // start stays latched
    stimulus.push_back(control_step(F_RESTART));                      // restart into pause
    stimulus.push_back(control_step(F_FINISH));                       // finish from pause
    stimulus.push_back(control_step(0));                              // latched start is taken
    stimulus.push_back(control_step(F_EMERG));
    stimulus.push_back(control_step(F_NO_CARD));                      // card pulled in emergency
    stimulus.push_back(control_step(F_EMERG | F_FINISH));             // finish left latched
    stimulus.push_back(control_step(0));                              // emergency sees finish
    stimulus.push_back(control_step(F_START));
    stimulus.push_back(control_step(F_FINISH));                       // finish while driving
    drive_items();
    drain();

    // random phases, idling switched per phase so both sides see busy and
    // quiet stretches; one phase holds the output off while input keeps coming
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      apply_setting(counts[p], fwds[p], limits[p]);
      mode      = p % 4;
      send_idle = (mode == 0) || (mode == 2);
      recv_idle = (mode == 0) || (mode == 3);
      if (p == 3) begin
        send_idle      = 1'b0;
        hold_requested = 1'b1;
      end
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) stimulus.push_back(random_item());
      drive_items();
      drain();
    end

    $display("covered %0d input transfers (%0d card line writes), %0d results checked",
             items_sent, line_writes, sb.checked);
    $display("over %0d register settings, with and without idling and one long output hold",
             settings_used);
    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
